@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the breadth-first grid block.
// Depends on a clk_i and rst_ni signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GBFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gbfs assertion failed");

// Implication from a trigger to a consequence in the next cycle.
`define GBFS_ASSERT_NEXT(label, trig, cons) \
  `GBFS_ASSERT(label, (trig) |=> (cons))

`endif

@@ sv/gbfs_pkg.sv @@
// Package of the breadth-first grid distance block: field widths, defaults,
// request codes and the sequencer state type. No dependencies.
package gbfs_pkg;

  localparam int GRID_ROWS_DEF = 20;
  localparam int GRID_COLS_DEF = 25;

  localparam int FUNC_W      = 2;
  localparam int ROW_IN_W    = 5;
  localparam int COL_IN_W    = 5;
  localparam int DIST_OUT_W  = 10;
  localparam int COUNT_OUT_W = 9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_QUERY,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_NBR,
    ST_DONE
  } gbfs_state_e;

endpackage

@@ sv/gbfs_ifs.sv @@
// Request and response channel interfaces of the breadth-first grid block.
// Depends on gbfs_pkg for the payload widths.
interface gbfs_req_if import gbfs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FUNC_W-1:0]      func;
  logic [ROW_IN_W-1:0]    cell_row;
  logic [COL_IN_W-1:0]    cell_col;
  logic                   is_wall;

  modport source (output valid, output func, output cell_row, output cell_col,
                  output is_wall, input ready);
  modport sink   (input valid, input func, input cell_row, input cell_col,
                  input is_wall, output ready);
endinterface

interface gbfs_rsp_if import gbfs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [DIST_OUT_W-1:0]  distance;
  logic [COUNT_OUT_W-1:0]        reached_count;

  modport source (output valid, output distance, output reached_count, input ready);
  modport sink   (input valid, input distance, input reached_count, output ready);
endinterface

@@ sv/grid_bfs_distance_map.sv @@
// Breadth-first distance map over a grid of cells, top level.
// Depends on gbfs_pkg, gbfs_req_if, gbfs_rsp_if and gbfs_ram.
//
// Requests arrive on req_i: a load writes one wall bit, a run walks the grid
// from a start cell, a query reads the distance of one cell. Run and query
// each give one response on rsp_o; a load gives none.
// A load leaves the block idle, and the next request may follow at once.
// A query does one memory read, then fills the response register once it is free.
// A run first clears the distance memory, then for every reached cell does one
// FIFO read and four neighbor read-check-write steps through the distance and
// wall memories, then posts the count.
// After reset a clearing pass over the whole grid opens every cell
// and sets every distance to unreachable; no request is taken meanwhile.
// Responses sit in an output register; when the receiver stalls, loads are
// still taken, and a run or query holds its result until the register frees.
module grid_bfs_distance_map import gbfs_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbfs_req_if.sink   req_i,
  gbfs_rsp_if.source rsp_o
);

  localparam int Cells = GRID_ROWS * GRID_COLS;
  localparam int AddrW = $clog2(Cells);
  localparam int CntW  = $clog2(Cells + 1);
  localparam int RowW  = $clog2(GRID_ROWS);
  localparam int ColW  = $clog2(GRID_COLS);
  localparam int DistW = $clog2(Cells) + 1;
  localparam int FifoW = RowW + ColW + DistW;
  localparam int CmpW  = 8;
  localparam logic [2:0] NbrCount = 3'd4;

  gbfs_state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [CntW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [RowW-1:0]  start_r_q, start_r_d, pend_r_q, pend_r_d;
  logic [ColW-1:0]  start_c_q, start_c_d, pend_c_q, pend_c_d;
  logic [AddrW-1:0] start_addr_q, start_addr_d, pend_addr_q, pend_addr_d;
  logic             start_ok_q, start_ok_d, q_ok_q, q_ok_d, pend_q, pend_d;
  logic [2:0]       nbr_q, nbr_d;
  logic             out_valid_q, out_valid_d;
  logic signed [DIST_OUT_W-1:0] out_dist_q, out_dist_d;
  logic [COUNT_OUT_W-1:0]       out_cnt_q, out_cnt_d;

  logic             wall_we, wall_wdata, wall_re, wall_rdata;
  logic [AddrW-1:0] wall_waddr, wall_raddr;
  logic             dist_we, dist_re;
  logic [AddrW-1:0] dist_waddr, dist_raddr;
  logic [DistW-1:0] dist_wdata, dist_rdata;
  logic signed [DistW-1:0] dist_rd_s;
  logic             fifo_we, fifo_re;
  logic [AddrW-1:0] fifo_waddr, fifo_raddr;
  logic [FifoW-1:0] fifo_wdata, fifo_rdata;

  logic             in_ok, out_free;
  logic [RowW-1:0]  in_r, cur_r, nb_r;
  logic [ColW-1:0]  in_c, cur_c, nb_c;
  logic [AddrW-1:0] in_addr, nb_addr;
  logic [DistW-1:0] cur_d, next_d;
  logic             nb_ok, take;

  assign in_ok   = (CmpW'(req_i.cell_row) < CmpW'(GRID_ROWS)) &&
                   (CmpW'(req_i.cell_col) < CmpW'(GRID_COLS));
  assign in_r    = RowW'(req_i.cell_row);
  assign in_c    = ColW'(req_i.cell_col);
  assign in_addr = AddrW'(AddrW'(in_r) * AddrW'(GRID_COLS) + AddrW'(in_c));

  assign cur_r  = fifo_rdata[FifoW-1 -: RowW];
  assign cur_c  = fifo_rdata[DistW +: ColW];
  assign cur_d  = fifo_rdata[DistW-1:0];
  assign next_d = cur_d + DistW'(1);

  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    unique case (nbr_q)
      3'd0: begin
        nb_r  = cur_r - RowW'(1);
        nb_ok = (cur_r != '0);
      end
      3'd1: begin
        nb_r  = cur_r + RowW'(1);
        nb_ok = (cur_r != RowW'(GRID_ROWS - 1));
      end
      3'd2: begin
        nb_c  = cur_c - ColW'(1);
        nb_ok = (cur_c != '0);
      end
      3'd3: begin
        nb_c  = cur_c + ColW'(1);
        nb_ok = (cur_c != ColW'(GRID_COLS - 1));
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_addr   = AddrW'(AddrW'(nb_r) * AddrW'(GRID_COLS) + AddrW'(nb_c));
  assign dist_rd_s = dist_rdata;
  assign take      = pend_q && (dist_rdata == '1) && !wall_rdata;
  assign out_free  = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    head_d       = head_q;
    tail_d       = tail_q;
    start_r_d    = start_r_q;
    start_c_d    = start_c_q;
    start_addr_d = start_addr_q;
    start_ok_d   = start_ok_q;
    q_ok_d       = q_ok_q;
    pend_d       = pend_q;
    pend_r_d     = pend_r_q;
    pend_c_d     = pend_c_q;
    pend_addr_d  = pend_addr_q;
    nbr_d        = nbr_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_dist_d   = out_dist_q;
    out_cnt_d    = out_cnt_q;
    wall_we      = 1'b0;
    wall_waddr   = in_addr;
    wall_wdata   = req_i.is_wall;
    wall_re      = 1'b0;
    wall_raddr   = nb_addr;
    dist_we      = 1'b0;
    dist_waddr   = clr_q;
    dist_wdata   = '1;
    dist_re      = 1'b0;
    dist_raddr   = in_addr;
    fifo_we      = 1'b0;
    fifo_waddr   = tail_q[AddrW-1:0];
    fifo_wdata   = {pend_r_q, pend_c_q, next_d};
    fifo_re      = 1'b0;
    fifo_raddr   = head_q[AddrW-1:0];

    unique case (state_q)
      ST_INIT: begin
        wall_we    = 1'b1;
        wall_waddr = clr_q;
        wall_wdata = 1'b0;
        dist_we    = 1'b1;
        if (clr_q == AddrW'(Cells - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.func)
            FUNC_LOAD: begin
              wall_we = in_ok;
            end
            FUNC_RUN: begin
              head_d       = '0;
              tail_d       = '0;
              clr_d        = '0;
              start_r_d    = in_r;
              start_c_d    = in_c;
              start_addr_d = in_addr;
              start_ok_d   = in_ok;
              state_d      = ST_CLEAR;
            end
            FUNC_QUERY: begin
              dist_re = in_ok;
              q_ok_d  = in_ok;
              state_d = ST_QUERY;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_QUERY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dist_d  = q_ok_q ? DIST_OUT_W'(dist_rd_s) : '1;
          out_cnt_d   = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        dist_we = 1'b1;
        if (clr_q == AddrW'(Cells - 1)) begin
          clr_d   = '0;
          state_d = ST_SEED;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_SEED: begin
        if (start_ok_q) begin
          dist_we    = 1'b1;
          dist_waddr = start_addr_q;
          dist_wdata = '0;
          fifo_we    = 1'b1;
          fifo_waddr = '0;
          fifo_wdata = {start_r_q, start_c_q, DistW'(0)};
          tail_d     = CntW'(1);
          state_d    = ST_POP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          state_d = ST_DONE;
        end else begin
          fifo_re = 1'b1;
          head_d  = head_q + CntW'(1);
          nbr_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        if (take) begin
          dist_we    = 1'b1;
          dist_waddr = pend_addr_q;
          dist_wdata = next_d;
          fifo_we    = 1'b1;
          tail_d     = tail_q + CntW'(1);
        end
        if (nbr_q != NbrCount) begin
          dist_re     = nb_ok;
          dist_raddr  = nb_addr;
          wall_re     = nb_ok;
          pend_d      = nb_ok;
          pend_r_d    = nb_r;
          pend_c_d    = nb_c;
          pend_addr_d = nb_addr;
          nbr_d       = nbr_q + 3'd1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_POP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dist_d  = '0;
          out_cnt_d   = COUNT_OUT_W'(tail_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      nbr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      nbr_q       <= nbr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_r_q    <= start_r_d;
    start_c_q    <= start_c_d;
    start_addr_q <= start_addr_d;
    start_ok_q   <= start_ok_d;
    q_ok_q       <= q_ok_d;
    pend_r_q     <= pend_r_d;
    pend_c_q     <= pend_c_d;
    pend_addr_q  <= pend_addr_d;
    out_dist_q   <= out_dist_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.distance      = out_dist_q;
  assign rsp_o.reached_count = out_cnt_q;

  gbfs_ram #(.Width(1), .Depth(Cells)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (wall_wdata),
    .re_i    (wall_re),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rdata)
  );

  gbfs_ram #(.Width(DistW), .Depth(Cells)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_re),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  gbfs_ram #(.Width(FifoW), .Depth(Cells)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .re_i    (fifo_re),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

endmodule

@@ sv/gbfs_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module gbfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sv/gbfs_checker.sv @@
// Port-level checker of the breadth-first grid block and its bind statement.
// Depends on gbfs_pkg, assert_macros.svh and grid_bfs_distance_map.
`include "assert_macros.svh"

module gbfs_checker import gbfs_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [FUNC_W-1:0]             req_func_i,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  logic signed [DIST_OUT_W-1:0]  rsp_distance_i,
  input  logic [COUNT_OUT_W-1:0]        rsp_count_i
);

  logic req_fire, rsp_stall, busy_req, load_req;

  assign req_fire  = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign busy_req  = req_fire && ((req_func_i == FUNC_RUN) || (req_func_i == FUNC_QUERY));
  assign load_req  = req_fire && (req_func_i == FUNC_LOAD);

  `GBFS_ASSERT_NEXT(a_rsp_hold, rsp_stall,
    rsp_valid_i && $stable(rsp_distance_i) && $stable(rsp_count_i))
  `GBFS_ASSERT_NEXT(a_busy_after_search, busy_req, !req_ready_i)
  `GBFS_ASSERT_NEXT(a_load_keeps_ready, load_req, req_ready_i)
  `GBFS_ASSERT(a_rsp_kind, rsp_valid_i |-> ((rsp_count_i == '0) || (rsp_distance_i == '0)))

endmodule

bind grid_bfs_distance_map gbfs_checker u_gbfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_func_i     (req_i.func),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_distance_i (rsp_o.distance),
  .rsp_count_i    (rsp_o.reached_count)
);
